FILE: hw/rtl/bcs_pkg.sv
// Shared constants, types and state codes for the bad-character substring search block.
package bcs_pkg;

  localparam int MAX_TEXT    = 256;
  localparam int MAX_PATTERN = 64;
  localparam int ALPHABET    = 256;
  localparam int STEP_LIMIT  = (MAX_TEXT + 1) * (MAX_PATTERN + 2) * 4;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 9;

  localparam int TA_W   = $clog2(MAX_TEXT);
  localparam int PA_W   = $clog2(MAX_PATTERN);
  localparam int ALPH_W = $clog2(ALPHABET);
  localparam int TL_W   = $clog2(MAX_TEXT + 1);
  localparam int JV_W   = $clog2(MAX_PATTERN + 1);
  localparam int K_W    = JV_W + 1;
  localparam int J_W    = $clog2(MAX_TEXT + MAX_PATTERN) + 1;
  localparam int STEP_W = $clog2(STEP_LIMIT + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  typedef enum logic [1:0] {
    CMD_PATTERN,
    CMD_TEXT,
    CMD_TEXT_LAST
  } cmd_e;

  typedef struct packed {
    cmd_e                    kind;
    logic [BYTE_W-1:0]       value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_FILL,
    ST_CHECK,
    ST_CMP,
    ST_JUMP,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/bcs_if.sv
// Valid/ready channel interfaces for the input bytes and the search results.
interface bcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [bcs_pkg::BYTE_W-1:0]    byte_value;
  logic                          is_last;

  modport source (output valid, opcode, byte_value, is_last, input ready);
  modport sink   (input valid, opcode, byte_value, is_last, output ready);
endinterface

interface bcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic signed [bcs_pkg::IDX_W-1:0] match_index;
  logic                          overflowed;

  modport source (output valid, found, match_index, overflowed, input ready);
  modport sink   (input valid, found, match_index, overflowed, output ready);
endinterface

FILE: hw/rtl/bad_char_substring_search.sv
// Top level of the bad-character substring search block.
// Usage:
//   in_i carries one byte per beat: opcode 0 loads a pattern byte, opcode 1 a text
//   byte; a text beat with is_last set closes the job and starts the search.
//   Pattern bytes should precede the text bytes of the same job. Bytes past 64
//   pattern or 256 text entries are dropped and reported through overflowed.
//   res_o carries one beat per job: found, match_index (-1 when absent) and
//   overflowed. Both stores are emptied once the result is taken into the
//   output register.
// Operation:
//   Load beats are taken one per cycle through a four-beat command queue while
//   the queue has room. After the closing beat the back end presets all 256 jump
//   table entries to the pattern length, writes each pattern byte's distance from
//   the pattern end into the table, then compares the window from its right end:
//   a match steps left and a mismatch jumps by the table entry of the text byte;
//   the walk is bounded at 67848 steps. A final check and the emit state follow;
//   the result is loaded into the output register when the emit state is left.
// Reset clears the lengths, the overflow flag, the queue and the output valid;
//   store contents need no clearing. When res_o stalls, the result holds in the
//   output register, the next search waits to emit, and input beats keep being
//   taken until the queue is full.
module bad_char_substring_search (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcs_in_if.sink    in_i,
  bcs_out_if.source res_o
);

  logic          cmd_valid;
  logic          cmd_ready;
  bcs_pkg::cmd_t cmd;

  bcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  bcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_o       (res_o)
  );

endmodule

FILE: hw/rtl/bcs_front.sv
// Front end: accept input beats, classify them into commands and queue them for the back end.
module bcs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bcs_in_if.sink        in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output bcs_pkg::cmd_t cmd_o
);

  bcs_pkg::cmd_t                   queue_q [bcs_pkg::QUEUE_DEPTH];
  logic [bcs_pkg::QP_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [bcs_pkg::QP_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [bcs_pkg::QC_W-1:0]        count_q, count_d;
  bcs_pkg::cmd_t                   beat_cmd;
  logic                            push;
  logic                            pop;

  always_comb begin
    beat_cmd.value = in_i.byte_value;
    unique case (in_i.opcode)
      bcs_pkg::OP_PATTERN: beat_cmd.kind = bcs_pkg::CMD_PATTERN;
      bcs_pkg::OP_TEXT:    beat_cmd.kind = in_i.is_last ? bcs_pkg::CMD_TEXT_LAST
                                                        : bcs_pkg::CMD_TEXT;
      default:             beat_cmd.kind = bcs_pkg::CMD_PATTERN;
    endcase
  end

  assign in_i.ready  = (count_q != bcs_pkg::QC_W'(bcs_pkg::QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= beat_cmd;
    end
  end

endmodule

FILE: hw/rtl/bcs_back.sv
// Back end: byte stores, jump table build, scan sequencer and result register.
module bcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  bcs_pkg::cmd_t cmd_i,
  bcs_out_if.source     res_o
);

  localparam logic signed [bcs_pkg::J_W-1:0] J_ONE = 1;
  localparam logic signed [bcs_pkg::K_W-1:0] K_ONE = 1;

  logic [bcs_pkg::BYTE_W-1:0] text_mem [bcs_pkg::MAX_TEXT];
  logic [bcs_pkg::BYTE_W-1:0] pat_mem  [bcs_pkg::MAX_PATTERN];
  logic [bcs_pkg::JV_W-1:0]   jump_mem [bcs_pkg::ALPHABET];

  logic [bcs_pkg::BYTE_W-1:0] text_rd_q, pat_rd_q;
  logic [bcs_pkg::JV_W-1:0]   jump_rd_q;

  bcs_pkg::state_e            state_q, state_d;
  logic [bcs_pkg::TL_W-1:0]   text_len_q, text_len_d;
  logic [bcs_pkg::JV_W-1:0]   pat_len_q, pat_len_d;
  logic                       ovf_q, ovf_d;
  logic [bcs_pkg::ALPH_W-1:0] init_cnt_q, init_cnt_d;
  logic [bcs_pkg::JV_W-1:0]   fill_idx_q, fill_idx_d;
  logic [bcs_pkg::JV_W-1:0]   fill_pos_q, fill_pos_d;
  logic                       fill_rd_q, fill_rd_d;
  logic signed [bcs_pkg::J_W-1:0] j_q, j_d, w_q, w_d;
  logic signed [bcs_pkg::K_W-1:0] k_q, k_d;
  logic [bcs_pkg::STEP_W-1:0] steps_q, steps_d;
  logic                       res_found_q, res_found_d;
  logic [bcs_pkg::IDX_W-1:0]  res_idx_q, res_idx_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_found_q;
  logic [bcs_pkg::IDX_W-1:0]  out_idx_q;
  logic                       out_ovf_q;

  logic                       text_we, pat_we, jump_we;
  logic [bcs_pkg::TA_W-1:0]   text_waddr, text_raddr;
  logic [bcs_pkg::PA_W-1:0]   pat_waddr, pat_raddr;
  logic [bcs_pkg::ALPH_W-1:0] jump_waddr;
  logic [bcs_pkg::JV_W-1:0]   jump_wdata;
  logic                       out_load;

  logic signed [bcs_pkg::K_W-1:0] k_top;
  logic signed [bcs_pkg::J_W-1:0] j_top, n_s, j_plus, j_jump, w_next;
  logic                       running;
  logic                       fill_more;

  assign k_top     = $signed({1'b0, pat_len_q} - bcs_pkg::K_W'(1));
  assign j_top     = bcs_pkg::J_W'(k_top);
  assign n_s       = bcs_pkg::J_W'($signed({1'b0, text_len_q}));
  assign j_plus    = j_q + J_ONE;
  assign w_next    = w_q + J_ONE;
  assign j_jump    = j_q + bcs_pkg::J_W'($signed({1'b0, jump_rd_q}));
  assign running   = (j_q < n_s) && !k_q[bcs_pkg::K_W-1];
  assign fill_more = (fill_idx_q < pat_len_q);

  assign text_raddr = j_q[bcs_pkg::TA_W-1:0];
  assign pat_raddr  = (state_q == bcs_pkg::ST_FILL) ? fill_idx_q[bcs_pkg::PA_W-1:0]
                                                     : k_q[bcs_pkg::PA_W-1:0];

  always_comb begin
    state_d     = state_q;
    text_len_d  = text_len_q;
    pat_len_d   = pat_len_q;
    ovf_d       = ovf_q;
    init_cnt_d  = init_cnt_q;
    fill_idx_d  = fill_idx_q;
    fill_pos_d  = fill_pos_q;
    fill_rd_d   = fill_rd_q;
    j_d         = j_q;
    k_d         = k_q;
    w_d         = w_q;
    steps_d     = steps_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    cmd_ready_o = 1'b0;
    out_load    = 1'b0;
    text_we     = 1'b0;
    pat_we      = 1'b0;
    jump_we     = 1'b0;
    text_waddr  = text_len_q[bcs_pkg::TA_W-1:0];
    pat_waddr   = pat_len_q[bcs_pkg::PA_W-1:0];
    jump_waddr  = init_cnt_q;
    jump_wdata  = pat_len_q;

    unique case (state_q)
      bcs_pkg::ST_LOAD: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          unique case (cmd_i.kind) inside
            bcs_pkg::CMD_PATTERN: begin
              if (pat_len_q < bcs_pkg::JV_W'(bcs_pkg::MAX_PATTERN)) begin
                pat_we    = 1'b1;
                pat_len_d = pat_len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            bcs_pkg::CMD_TEXT, bcs_pkg::CMD_TEXT_LAST: begin
              if (text_len_q < bcs_pkg::TL_W'(bcs_pkg::MAX_TEXT)) begin
                text_we    = 1'b1;
                text_len_d = text_len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
              if (cmd_i.kind == bcs_pkg::CMD_TEXT_LAST) begin
                state_d    = bcs_pkg::ST_INIT;
                init_cnt_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      bcs_pkg::ST_INIT: begin
        jump_we    = 1'b1;
        init_cnt_d = init_cnt_q + 1'b1;
        if (init_cnt_q == '1) begin
          state_d    = bcs_pkg::ST_FILL;
          fill_idx_d = '0;
          fill_rd_d  = 1'b0;
        end
      end
      bcs_pkg::ST_FILL: begin
        fill_rd_d  = fill_more;
        fill_pos_d = fill_idx_q;
        if (fill_more) begin
          fill_idx_d = fill_idx_q + 1'b1;
        end
        if (fill_rd_q) begin
          jump_we    = 1'b1;
          jump_waddr = pat_rd_q;
          jump_wdata = pat_len_q - fill_pos_q - bcs_pkg::JV_W'(1);
        end
        if (!fill_more && !fill_rd_q) begin
          state_d = bcs_pkg::ST_CHECK;
          j_d     = j_top;
          k_d     = k_top;
          w_d     = j_top;
          steps_d = '0;
        end
      end
      bcs_pkg::ST_CHECK: begin
        if (!running) begin
          res_found_d = k_q[bcs_pkg::K_W-1];
          res_idx_d   = k_q[bcs_pkg::K_W-1] ? bcs_pkg::IDX_W'(j_plus) : '1;
          state_d     = bcs_pkg::ST_EMIT;
        end else if (steps_q == bcs_pkg::STEP_W'(bcs_pkg::STEP_LIMIT)) begin
          res_found_d = 1'b0;
          res_idx_d   = '1;
          state_d     = bcs_pkg::ST_EMIT;
        end else begin
          steps_d = steps_q + 1'b1;
          if (j_q[bcs_pkg::J_W-1]) begin
            j_d = w_next;
            k_d = k_top;
            w_d = w_next;
          end else begin
            state_d = bcs_pkg::ST_CMP;
          end
        end
      end
      bcs_pkg::ST_CMP: begin
        if (text_rd_q == pat_rd_q) begin
          j_d     = j_q - J_ONE;
          k_d     = k_q - K_ONE;
          state_d = bcs_pkg::ST_CHECK;
        end else begin
          state_d = bcs_pkg::ST_JUMP;
        end
      end
      bcs_pkg::ST_JUMP: begin
        j_d     = j_jump;
        k_d     = k_top;
        w_d     = j_jump;
        state_d = bcs_pkg::ST_CHECK;
      end
      bcs_pkg::ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_load   = 1'b1;
          text_len_d = '0;
          pat_len_d  = '0;
          ovf_d      = 1'b0;
          state_d    = bcs_pkg::ST_LOAD;
        end
      end
      default: state_d = bcs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcs_pkg::ST_LOAD;
      text_len_q  <= '0;
      pat_len_q   <= '0;
      ovf_q       <= 1'b0;
      init_cnt_q  <= '0;
      fill_idx_q  <= '0;
      fill_pos_q  <= '0;
      fill_rd_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      text_len_q  <= text_len_d;
      pat_len_q   <= pat_len_d;
      ovf_q       <= ovf_d;
      init_cnt_q  <= init_cnt_d;
      fill_idx_q  <= fill_idx_d;
      fill_pos_q  <= fill_pos_d;
      fill_rd_q   <= fill_rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    k_q         <= k_d;
    w_q         <= w_d;
    steps_q     <= steps_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (out_load) begin
      out_found_q <= res_found_q;
      out_idx_q   <= res_idx_q;
      out_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= cmd_i.value;
    end
    text_rd_q <= text_mem[text_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= cmd_i.value;
    end
    pat_rd_q <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (jump_we) begin
      jump_mem[jump_waddr] <= jump_wdata;
    end
    jump_rd_q <= jump_mem[text_rd_q];
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.found       = out_found_q;
  assign res_o.match_index = $signed(out_idx_q);
  assign res_o.overflowed  = out_ovf_q;

endmodule

FILE: hw/rtl/bcs_checker.sv
// Port-level checker for the substring search block, bound to the top level.
module bcs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_opcode_i,
  input logic                      in_is_last_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic                      res_found_i,
  input logic [bcs_pkg::IDX_W-1:0] res_match_index_i,
  input logic                      res_overflowed_i
);

  logic [3:0] jobs_q, jobs_d;
  logic       job_in;
  logic       job_out;

  assign job_in  = in_valid_i && in_ready_i && (in_opcode_i == bcs_pkg::OP_TEXT) &&
                   in_is_last_i;
  assign job_out = res_valid_i && res_ready_i;

  always_comb begin
    jobs_d = jobs_q;
    if (job_in && !job_out) begin
      jobs_d = jobs_q + 1'b1;
    end else if (job_out && !job_in && jobs_q != '0) begin
      jobs_d = jobs_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jobs_q <= '0;
    end else begin
      jobs_q <= jobs_d;
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat withdrawn before it was taken");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_found_i) && $stable(res_match_index_i) &&
                                    $stable(res_overflowed_i))
    else $error("stalled result beat changed");

  a_res_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> jobs_q != '0)
    else $error("result beat without a closing text beat");

  a_not_found_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_match_index_i == '1)
    else $error("not-found result carries an index other than -1");

  a_found_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_found_i |-> !res_match_index_i[bcs_pkg::IDX_W-1])
    else $error("found result carries a negative index");

endmodule

bind bad_char_substring_search bcs_checker u_bcs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_opcode_i       (in_i.opcode),
  .in_is_last_i      (in_i.is_last),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_found_i       (res_o.found),
  .res_match_index_i (res_o.match_index),
  .res_overflowed_i  (res_o.overflowed)
);
